>>> rtl/max_pool_2d_with_argmax_top_macros.svh
// assertion macros shared by the max pooling rtl
// expects clk and arst_n in the scope of the including module
`ifndef MAX_POOL_2D_WITH_ARGMAX_TOP_MACROS_SVH
`define MAX_POOL_2D_WITH_ARGMAX_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define MP2A_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define MP2A_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/mp2a_pkg.sv
// shared types and constants for the max pooling block
// no dependencies
package mp2a_pkg;

	localparam int MAX_COLS = 256;
	localparam int MAX_POOL = 8;
	localparam int ROW_LIMIT = 256;
	localparam int SAMPLE_W = 16;
	localparam int POOLED_W = 15;
	localparam int IDX_W = 8;
	localparam int OFF_W = 3;
	localparam int MAP_W = 9;
	localparam int POOL_W = 4;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int ENTRY_W = SAMPLE_W + 2 * OFF_W;

	// register indexes on the configuration port
	typedef enum logic [1:0] {
		REG_MAP_COLS  = 2'd0,
		REG_MAP_ROWS  = 2'd1,
		REG_POOL_COLS = 2'd2,
		REG_POOL_ROWS = 2'd3
	} reg_idx_t;

	// sizes after clamping, plus a restart pulse on any write
	typedef struct packed {
		logic [MAP_W-1:0]  mc;
		logic [MAP_W-1:0]  mr;
		logic [POOL_W-1:0] pc;
		logic [POOL_W-1:0] pr;
		logic              restart;
	} cfg_t;

	// position of the current sample within the map
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [OFF_W-1:0] wr;
		logic [OFF_W-1:0] wc;
		logic             in_win;
		logic             emit;
		logic             done;
	} pos_t;

	// one column store entry: running maximum and packed offsets
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] max;
		logic [OFF_W-1:0]           row;
		logic [OFF_W-1:0]           col;
	} entry_t;

endpackage

>>> rtl/mp2a_cfg.sv
// apb configuration registers with size clamping
// depends on mp2a_pkg
module mp2a_cfg import mp2a_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [MAP_W-1:0]  map_cols_q;
	logic [MAP_W-1:0]  map_rows_q;
	logic [POOL_W-1:0] pool_cols_q;
	logic [POOL_W-1:0] pool_rows_q;
	logic              wr_en;
	reg_idx_t          sel;

	assign pready = 1'b1;
	assign sel = reg_idx_t'(paddr[3:2]);
	assign wr_en = psel && penable && pwrite && pready;

	// register writes, any write restarts the map position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_cols_q <= MAP_W'(24);
			map_rows_q <= MAP_W'(24);
			pool_cols_q <= POOL_W'(2);
			pool_rows_q <= POOL_W'(2);
		end else begin
			if (wr_en) begin
				case (sel)
					REG_MAP_COLS:  map_cols_q <= pwdata[MAP_W-1:0];
					REG_MAP_ROWS:  map_rows_q <= pwdata[MAP_W-1:0];
					REG_POOL_COLS: pool_cols_q <= pwdata[POOL_W-1:0];
					REG_POOL_ROWS: pool_rows_q <= pwdata[POOL_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		case (sel)
			REG_MAP_COLS:  prdata = DATA_W'(map_cols_q);
			REG_MAP_ROWS:  prdata = DATA_W'(map_rows_q);
			REG_POOL_COLS: prdata = DATA_W'(pool_cols_q);
			REG_POOL_ROWS: prdata = DATA_W'(pool_rows_q);
			default:       prdata = '0;
		endcase
	end

	// zero acts as one, oversize saturates; restart at the writing edge
	always_comb begin
		cfg.mc = (map_cols_q == '0) ? MAP_W'(1) :
			((map_cols_q > MAP_W'(MAX_COLS)) ? MAP_W'(MAX_COLS) : map_cols_q);
		cfg.mr = (map_rows_q == '0) ? MAP_W'(1) :
			((map_rows_q > MAP_W'(ROW_LIMIT)) ? MAP_W'(ROW_LIMIT) : map_rows_q);
		cfg.pc = (pool_cols_q == '0) ? POOL_W'(1) :
			((pool_cols_q > POOL_W'(MAX_POOL)) ? POOL_W'(MAX_POOL) : pool_cols_q);
		cfg.pr = (pool_rows_q == '0) ? POOL_W'(1) :
			((pool_rows_q > POOL_W'(MAX_POOL)) ? POOL_W'(MAX_POOL) : pool_rows_q);
		cfg.restart = wr_en;
	end

endmodule

>>> rtl/mp2a_pos.sv
// raster position tracking: map row/column, window offsets, column index
// depends on mp2a_pkg
module mp2a_pos import mp2a_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic adv,
	output pos_t pos
);

	logic [MAP_W-1:0] c_q;
	logic [MAP_W-1:0] r_q;
	logic [MAP_W-1:0] cbase_q;
	logic [MAP_W-1:0] rbase_q;
	logic [IDX_W-1:0] idx_q;
	logic [OFF_W-1:0] wc_q;
	logic [OFF_W-1:0] wr_q;
	logic             in_cols;
	logic             in_rows;
	logic             last_wc;
	logic             last_wr;
	logic             last_col_win;
	logic             last_row_win;
	logic             row_end;
	logic             map_end;

	// window fit and end-of-window tests
	always_comb begin
		in_cols = ({1'b0, cbase_q} + (MAP_W + 1)'(cfg.pc)) <= {1'b0, cfg.mc};
		in_rows = ({1'b0, rbase_q} + (MAP_W + 1)'(cfg.pr)) <= {1'b0, cfg.mr};
		last_wc = ({1'b0, wc_q} + (OFF_W + 1)'(1)) >= cfg.pc;
		last_wr = ({1'b0, wr_q} + (OFF_W + 1)'(1)) >= cfg.pr;
		last_col_win = ({1'b0, cbase_q} + (MAP_W + 1)'({cfg.pc, 1'b0})) > {1'b0, cfg.mc};
		last_row_win = ({1'b0, rbase_q} + (MAP_W + 1)'({cfg.pr, 1'b0})) > {1'b0, cfg.mr};
		row_end = ({1'b0, c_q} + (MAP_W + 1)'(1)) >= {1'b0, cfg.mc};
		map_end = ({1'b0, r_q} + (MAP_W + 1)'(1)) >= {1'b0, cfg.mr};
		pos.idx = idx_q;
		pos.wr = wr_q;
		pos.wc = wc_q;
		pos.in_win = in_cols && in_rows;
		pos.emit = in_cols && in_rows && last_wc && last_wr;
		pos.done = in_cols && in_rows && last_wc && last_wr && last_col_win && last_row_win;
	end

	// counters step on each accepted sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q <= '0;
			r_q <= '0;
			cbase_q <= '0;
			rbase_q <= '0;
			idx_q <= '0;
			wc_q <= '0;
			wr_q <= '0;
		end else if (cfg.restart) begin
			c_q <= '0;
			r_q <= '0;
			cbase_q <= '0;
			rbase_q <= '0;
			idx_q <= '0;
			wc_q <= '0;
			wr_q <= '0;
		end else if (adv) begin
			if (row_end) begin
				c_q <= '0;
				cbase_q <= '0;
				idx_q <= '0;
				wc_q <= '0;
				if (map_end) begin
					r_q <= '0;
					rbase_q <= '0;
					wr_q <= '0;
				end else begin
					r_q <= r_q + MAP_W'(1);
					if (in_rows) begin
						if (last_wr) begin
							wr_q <= '0;
							rbase_q <= rbase_q + MAP_W'(cfg.pr);
						end else begin
							wr_q <= wr_q + OFF_W'(1);
						end
					end
				end
			end else begin
				c_q <= c_q + MAP_W'(1);
				if (in_cols && in_rows) begin
					if (last_wc) begin
						wc_q <= '0;
						idx_q <= idx_q + IDX_W'(1);
						cbase_q <= cbase_q + MAP_W'(cfg.pc);
					end else begin
						wc_q <= wc_q + OFF_W'(1);
					end
				end
			end
		end
	end

endmodule

>>> rtl/mp2a_ram.sv
// column store: running maximum and offsets per window column
// one write and one registered read per cycle, depends on mp2a_pkg
module mp2a_ram import mp2a_pkg::*; (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  entry_t           wdata,
	input  logic             re,
	input  logic [IDX_W-1:0] raddr,
	output entry_t           rdata
);

	entry_t mem [MAX_COLS];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/max_pool_2d_with_argmax_top.sv
// Streaming 2-D max pooling with argmax over a raster of signed Q1.15 samples.
// One sample is taken every clock unless the input stalls. A window's result
// is formed in stage 1 once its closing sample is accepted and then waits in
// an output register. Each sample does one read-modify-write of the 256-entry
// column store (one read port, one write port): read at acceptance, written
// as it leaves stage 1, the write forwarded to a read of the same entry in the
// same cycle. Input stalls only while the next window-closing sample is ready
// and the previous result is still held by a stalled sink. The column store
// needs no clearing after reset. Configuration writes restart the map position
// and must be made with no transaction in flight.
// depends on mp2a_pkg, mp2a_cfg, mp2a_pos, mp2a_ram and the macros header
`include "max_pool_2d_with_argmax_top_macros.svh"

module max_pool_2d_with_argmax_top import mp2a_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ADDR_W-1:0]          paddr,
	input  logic [DATA_W-1:0]          pwdata,
	output logic [DATA_W-1:0]          prdata,
	output logic                       pready,
	// sample input
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	// pooled output
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [POOLED_W-1:0]        pooled_value,
	output logic [OFF_W-1:0]           max_row_offset,
	output logic [OFF_W-1:0]           max_col_offset,
	output logic                       map_done
);

	cfg_t                       cfg;
	pos_t                       pos;
	pos_t                       pos_s1;
	logic                       valid_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic                       fwd_s1;
	entry_t                     fwd_q;
	entry_t                     rd_data;
	entry_t                     old_entry;
	entry_t                     new_entry;
	logic                       accept;
	logic                       s1_go;
	logic                       mem_we;
	logic                       out_valid_q;
	logic [POOLED_W-1:0]        pooled_q;
	logic [OFF_W-1:0]           row_q;
	logic [OFF_W-1:0]           col_q;
	logic                       done_q;

	mp2a_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mp2a_pos u_pos (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.adv    (accept),
		.pos    (pos)
	);

	mp2a_ram u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (pos_s1.idx),
		.wdata (new_entry),
		.re    (accept),
		.raddr (pos.idx),
		.rdata (rd_data)
	);

	// handshake: stage 1 only blocks when it holds a result and the output is full
	assign s1_go = valid_s1 && (!pos_s1.emit || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_go;
	assign accept = in_valid && !in_stall;
	assign mem_we = s1_go && pos_s1.in_win;

	// read-modify-write of the column entry, first sample of a window overwrites
	always_comb begin
		old_entry = fwd_s1 ? fwd_q : rd_data;
		new_entry = old_entry;
		if ((pos_s1.wr == '0 && pos_s1.wc == '0) || (sample_s1 > old_entry.max)) begin
			new_entry.max = sample_s1;
			new_entry.row = pos_s1.wr;
			new_entry.col = pos_s1.wc;
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				fwd_s1 <= mem_we && (pos_s1.idx == pos.idx);
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
				fwd_s1 <= 1'b0;
			end
		end
	end

	// stage 1 payload and forwarded entry
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			pos_s1 <= pos;
		end
		if (mem_we) begin
			fwd_q <= new_entry;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (s1_go && pos_s1.emit) || (out_valid_q && out_stall);
		end
	end

	// output payload, maximum floored at zero
	always_ff @(posedge clk) begin
		if (s1_go && pos_s1.emit) begin
			pooled_q <= new_entry.max[SAMPLE_W-1] ? '0 : new_entry.max[POOLED_W-1:0];
			row_q <= new_entry.row;
			col_q <= new_entry.col;
			done_q <= pos_s1.done;
		end
	end

	assign out_valid = out_valid_q;
	assign pooled_value = pooled_q;
	assign max_row_offset = row_q;
	assign max_col_offset = col_q;
	assign map_done = done_q;

	// checks
	`MP2A_ASSERT_NOW(a_stall_needs_full, in_stall, valid_s1 && pos_s1.emit && out_valid_q, "input stalled without a blocked result")
	`MP2A_ASSERT_NOW(a_fwd_needs_item, fwd_s1, valid_s1, "forward flag set with empty stage")
	`MP2A_ASSERT_NOW(a_emit_in_window, valid_s1 && pos_s1.emit, pos_s1.in_win, "result outside a full window")
	`MP2A_ASSERT_NEXT(a_result_loaded, s1_go && pos_s1.emit, out_valid_q, "result lost on the way to the output")

endmodule

>>> verif/testbench.sv
// self-checking testbench for max_pool_2d_with_argmax_top: raster samples in, pooled maxima out
// a scoreboard class predicts every window result and checks it field by field
// depends on mp2a_pkg and the max pooling rtl
module testbench import mp2a_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TARGET_ITEMS  = 1450;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 8;

	// one pooled window as seen on the output ports
	typedef struct packed {
		logic [POOLED_W-1:0] pooled_value;
		logic [OFF_W-1:0]    max_row_offset;
		logic [OFF_W-1:0]    max_col_offset;
		logic                map_done;
	} pooled_t;

	// window predictor and store of pooled results still to come
	class pool_scoreboard;
		logic [MAP_W-1:0]           map_cols;
		logic [MAP_W-1:0]           map_rows;
		logic [POOL_W-1:0]          pool_cols;
		logic [POOL_W-1:0]          pool_rows;
		logic signed [SAMPLE_W-1:0] col_max [MAX_COLS];
		logic [OFF_W-1:0]           max_row [MAX_COLS];
		logic [OFF_W-1:0]           max_col [MAX_COLS];
		int                         row_pos;
		int                         col_pos;
		int                         band_row;
		int                         win_col;
		pooled_t                    expected_pools [$];
		int                         errors;
		int                         windows_checked;
		int                         maps_done;

		function new();
			map_cols = 24;
			map_rows = 24;
			pool_cols = 2;
			pool_rows = 2;
			errors = 0;
			windows_checked = 0;
			maps_done = 0;
			restart();
		endfunction

		static function int clamp_size(int v, int lim);
			if (v == 0)
				return 1;
			return (v > lim) ? lim : v;
		endfunction

		function void restart();
			row_pos = 0;
			col_pos = 0;
			band_row = 0;
			win_col = 0;
		endfunction

		function int pending();
			return expected_pools.size();
		endfunction

		// any register write also restarts the map position
		function void set_reg(reg_idx_t r, logic [DATA_W-1:0] data);
			case (r)
				REG_MAP_COLS:  map_cols = data[MAP_W-1:0];
				REG_MAP_ROWS:  map_rows = data[MAP_W-1:0];
				REG_POOL_COLS: pool_cols = data[POOL_W-1:0];
				REG_POOL_ROWS: pool_rows = data[POOL_W-1:0];
				default: ;
			endcase
			restart();
		endfunction

		// accepted sample: update the running column maximum, predict a result
		function void note_sample(logic signed [SAMPLE_W-1:0] s);
			int      mc;
			int      mr;
			int      pc;
			int      pr;
			int      full_c;
			int      full_r;
			int      idx;
			pooled_t res;
			mc = clamp_size(map_cols, MAX_COLS);
			mr = clamp_size(map_rows, ROW_LIMIT);
			pc = clamp_size(pool_cols, MAX_POOL);
			pr = clamp_size(pool_rows, MAX_POOL);
			full_c = (mc / pc) * pc;
			full_r = (mr / pr) * pr;
			if (col_pos < full_c && row_pos < full_r) begin
				idx = col_pos / pc;
				// first sample of a window opens the entry, later ones only on a strict rise
				if (band_row == 0 && win_col == 0) begin
					col_max[idx] = s;
					max_row[idx] = '0;
					max_col[idx] = '0;
				end else if (s > col_max[idx]) begin
					col_max[idx] = s;
					max_row[idx] = band_row[OFF_W-1:0];
					max_col[idx] = win_col[OFF_W-1:0];
				end
				if (band_row + 1 >= pr && win_col + 1 >= pc) begin
					res.pooled_value = (col_max[idx] < 0) ? '0 : col_max[idx][POOLED_W-1:0];
					res.max_row_offset = max_row[idx];
					res.max_col_offset = max_col[idx];
					res.map_done = (col_pos + 1 == full_c && row_pos + 1 == full_r);
					expected_pools.insert(expected_pools.size(), res);
				end
				win_col = (win_col + 1 >= pc) ? 0 : win_col + 1;
			end
			// advance the raster position
			if (col_pos + 1 >= mc) begin
				col_pos = 0;
				win_col = 0;
				if (row_pos < full_r)
					band_row = (band_row + 1 >= pr) ? 0 : band_row + 1;
				if (row_pos + 1 >= mr) begin
					row_pos = 0;
					band_row = 0;
				end else begin
					row_pos = row_pos + 1;
				end
			end else begin
				col_pos = col_pos + 1;
			end
		endfunction

		// accepted result against the oldest prediction
		function void check_pooled(logic [POOLED_W-1:0] value, logic [OFF_W-1:0] row,
				logic [OFF_W-1:0] col, logic done);
			pooled_t want;
			if (expected_pools.size() == 0) begin
				$error("unexpected pooled result: pooled_value %0d", value);
				errors++;
				return;
			end
			want = expected_pools.pop_front();
			if (value !== want.pooled_value) begin
				$error("pooled_value: expected %0d, got %0d", want.pooled_value, value);
				errors++;
			end
			if (row !== want.max_row_offset) begin
				$error("max_row_offset: expected %0d, got %0d", want.max_row_offset, row);
				errors++;
			end
			if (col !== want.max_col_offset) begin
				$error("max_col_offset: expected %0d, got %0d", want.max_col_offset, col);
				errors++;
			end
			if (done !== want.map_done) begin
				$error("map_done: expected %0d, got %0d", want.map_done, done);
				errors++;
			end
			windows_checked++;
			if (want.map_done)
				maps_done++;
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       psel = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite = 1'b0;
	logic [ADDR_W-1:0]          paddr = '0;
	logic [DATA_W-1:0]          pwdata = '0;
	logic [DATA_W-1:0]          prdata;
	logic                       pready;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [POOLED_W-1:0]        pooled_value;
	logic [OFF_W-1:0]           max_row_offset;
	logic [OFF_W-1:0]           max_col_offset;
	logic                       map_done;

	pool_scoreboard sb = new();
	int             items_sent = 0;
	int             settings_seen = 0;
	int             cycle_count;

	max_pool_2d_with_argmax_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sample         (sample),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pooled_value   (pooled_value),
		.max_row_offset (max_row_offset),
		.max_col_offset (max_col_offset),
		.map_done       (map_done)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// idling: sender light and sink heavy, then swapped, then none
	function automatic int send_idle_pct();
		if (items_sent < 480)
			return 21;
		if (items_sent < 960)
			return 71;
		return 0;
	endfunction

	function automatic int sink_stall_pct();
		if (items_sent < 480)
			return 71;
		if (items_sent < 960)
			return 21;
		return 0;
	endfunction

	// sink side: random stall, check every accepted transaction
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < sink_stall_pct());
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_pooled(pooled_value, max_row_offset, max_col_offset, map_done);
	end

	// mix of extremes, near-zero values for ties and full-range noise
	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		int small_val;
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2, 3: begin
				small_val = int'($urandom_range(0, 6)) - 3;
				return SAMPLE_W'(small_val);
			end
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	// one input transaction, entered just after an edge
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] v);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= v;
		do @(posedge clk); while (in_stall);
		sb.note_sample(v);
		items_sent++;
	endtask

	// stop sending and wait until every predicted window has come out
	task automatic drain_results();
		int waited;
		waited = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (sb.pending() != 0) begin
			$error("%0d pooled results never arrived", sb.pending());
			sb.errors++;
			sb.expected_pools.delete();
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// setup and access cycle; random bits above the register width
	task automatic apb_write(input reg_idx_t r, input int v);
		logic [DATA_W-1:0] data;
		data = $urandom();
		if (r == REG_MAP_COLS || r == REG_MAP_ROWS)
			data[MAP_W-1:0] = v[MAP_W-1:0];
		else
			data[POOL_W-1:0] = v[POOL_W-1:0];
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(r, data);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic configure(input int mc, input int mr, input int pc, input int pr);
		drain_results();
		apb_write(REG_MAP_COLS, mc);
		apb_write(REG_MAP_ROWS, mr);
		apb_write(REG_POOL_COLS, pc);
		apb_write(REG_POOL_ROWS, pr);
		settings_seen++;
	endtask

	task automatic send_random(input int n);
		for (int i = 0; i < n; i++)
			send_sample(pick_sample());
	endtask

	// watchdog
	initial begin
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int pattern [$];
		int mc;
		int mr;
		int pc;
		int pr;
		int n;
		int phase_no;

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// reset sizes: 24x24 map, 2x2 windows, two rows of samples
		send_random(48);

		// ties and an all-negative window
		configure(4, 2, 2, 2);
		pattern = '{-5, 32767, -32768, -7, 32767, 3, -7, -100};
		foreach (pattern[i])
			send_sample(SAMPLE_W'(pattern[i]));

		// partial windows: right-hand column and bottom row consumed without effect
		configure(5, 3, 2, 2);
		pattern = '{100, -1, 7, 7, 555,
			100, 20, 7, 8, -32768,
			32767, 32767, 32767, 32767, 32767};
		foreach (pattern[i])
			send_sample(SAMPLE_W'(pattern[i]));

		// zero sizes act as one: every sample is a whole map
		configure(0, 0, 0, 0);
		send_random(20);

		// oversized map width saturates at the store depth, one row
		configure(511, 1, 1, 1);
		send_random(256);

		// oversized pools against a one-column map: nothing fits
		configure(1, 511, 15, 15);
		send_random(40);

		// tallest map, eight-row windows, wraps once
		configure(1, 300, 0, 8);
		send_random(260);

		// largest windows
		configure(8, 16, 8, 8);
		send_random(128);

		// window larger than map
		configure(3, 3, 4, 4);
		send_random(20);

		// random settings, mostly small maps
		phase_no = 0;
		while (items_sent < TARGET_ITEMS) begin
			mc = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 12);
			mr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 10);
			pc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
			pr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
			n = pool_scoreboard::clamp_size(mc, MAX_COLS)
				* pool_scoreboard::clamp_size(mr, ROW_LIMIT) * $urandom_range(1, 2)
				+ $urandom_range(0, 3);
			if (n > 160)
				n = 160;
			if (n > TARGET_ITEMS - items_sent)
				n = TARGET_ITEMS - items_sent;
			configure(mc, mr, pc, pr);
			for (int i = 0; i < n; i++) begin
				// hold the sender mid-map until the output side has caught up
				if (phase_no % 3 == 0 && i == n / 2)
					drain_results();
				send_sample(pick_sample());
			end
			phase_no++;
		end

		drain_results();
		repeat (20) @(posedge clk);
		$display("covered %0d samples over %0d register settings plus the reset sizes",
			items_sent, settings_seen);
		$display("checked %0d pooled windows, %0d of them closing a map",
			sb.windows_checked, sb.maps_done);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
